// ===== rtl/est_pkg.sv =====
// shared types and constants for the event slot table
package est_pkg;

  localparam int SLOTS_DEFAULT = 64;
  localparam int EVENT_TYPES   = 4;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 7;

  localparam logic [1:0] CMD_RECORD = 2'd0;
  localparam logic [1:0] CMD_READ   = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SLOT_LIMIT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = CFG_IDX_W'(1);

  typedef struct packed {
    logic [1:0]  cmd;
    logic [1:0]  event_type;
    logic [31:0] user_ident;
    logic [31:0] session_ident;
    logic [31:0] event_code;
    logic [63:0] stamp;
    logic [63:0] lookup_id;
  } req_t;

  typedef struct packed {
    logic        failed;
    logic [63:0] out_id;
    logic [1:0]  out_type;
    logic [31:0] out_user;
    logic [31:0] out_session;
    logic [31:0] out_code;
    logic [63:0] out_stamp;
  } rsp_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] user;
    logic [31:0] session;
    logic [31:0] code;
    logic [63:0] stamp;
  } event_t;

  // transaction travelling down the cell row
  typedef struct packed {
    logic        valid;
    logic        rej;
    logic        hit;
    logic [1:0]  cmd;
    logic [63:0] id;
    event_t      ev;
  } pkt_t;

endpackage

// ===== rtl/est_req_if.sv =====
// command channel
interface est_req_if;
  import est_pkg::*;

  logic valid;
  logic ready;
  req_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

// ===== rtl/est_rsp_if.sv =====
// result channel
interface est_rsp_if;
  import est_pkg::*;

  logic valid;
  logic ready;
  rsp_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

// ===== rtl/est_cfg_if.sv =====
// register write channel
interface est_cfg_if;
  import est_pkg::*;

  logic valid;
  logic ready;
  cfg_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

// ===== rtl/est_cell.sv =====
// one slot of the table, acting on the transaction passing through
module est_cell #(
  parameter int CELL_INDEX = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic [6:0]    slot_limit,
  input  est_pkg::pkt_t pkt_in,
  output est_pkg::pkt_t pkt_out
);
  import est_pkg::*;

  logic [63:0] ident;
  logic [63:0] ident_next;
  event_t      ev;
  logic        wr;
  logic        live;
  pkt_t        pkt_next;

  assign live = pkt_in.valid && !pkt_in.rej && !pkt_in.hit
                && (CELL_INDEX < int'(slot_limit));

  always_comb begin
    pkt_next   = pkt_in;
    ident_next = ident;
    wr         = 1'b0;
    if (live) begin
      unique case (pkt_in.cmd)
        CMD_RECORD: begin
          if (ident == 64'd0) begin
            ident_next   = pkt_in.id;
            wr           = 1'b1;
            pkt_next.hit = 1'b1;
          end
        end
        CMD_READ: begin
          if (ident == pkt_in.id) begin
            pkt_next.ev  = ev;
            pkt_next.hit = 1'b1;
          end
        end
        CMD_CLEAR: begin
          if (ident == pkt_in.id) begin
            ident_next   = 64'd0;
            pkt_next.hit = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pkt_out.valid <= 1'b0;
      ident         <= 64'd0;
    end else if (adv) begin
      pkt_out <= pkt_next;
      ident   <= ident_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && wr) begin
      ev <= pkt_in.ev;
    end
  end

endmodule

// ===== rtl/event_slot_table_top.sv =====
// event slot table top level: command entry, cell row, result register
//
//   channel  role    transaction
//   req      sink    one command (record, read, clear)
//   rsp      source  one result per command
//   cfg      sink    one register write (slot_limit, enable)
//
// an accepted command passes the entry register, then the row of SLOTS cells, then the
// result register, the row holding one command at a time, so a new command is taken only
// once the previous result is registered
// rst clears identifiers, counters and registers
// a stalled result freezes the row once a command reaches the last cell; the next command is taken while it waits
module event_slot_table_top #(
  parameter int SLOTS = est_pkg::SLOTS_DEFAULT
) (
  input logic       clk,
  input logic       rst,
  est_req_if.sink   req,
  est_rsp_if.source rsp,
  est_cfg_if.sink   cfg
);
  import est_pkg::*;

  logic [6:0]  slot_limit;
  logic        enable;
  logic [63:0] next_ident;
  logic [6:0]  active_count;
  logic        busy;
  pkt_t        entry;
  pkt_t        chain [SLOTS];
  pkt_t        tail;
  logic        adv;
  logic        req_fire;
  logic [6:0]  lim;
  logic        rej;
  logic        is_record;
  logic        is_lookup;
  logic        ok;
  rsp_t        rsp_next;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_limit <= 7'd64;
      enable     <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.item.index)
        REG_SLOT_LIMIT: slot_limit <= cfg.item.data;
        REG_ENABLE:     enable     <= cfg.item.data[0];
        default: begin
        end
      endcase
    end
  end

  assign lim       = (int'(slot_limit) > SLOTS) ? 7'(SLOTS) : slot_limit;
  assign is_record = (req.item.cmd == CMD_RECORD);
  assign is_lookup = (req.item.cmd == CMD_READ) || (req.item.cmd == CMD_CLEAR);
  assign rej = !enable || !(is_record || is_lookup)
               || (is_record && ((int'(req.item.event_type) >= EVENT_TYPES)
                                 || (active_count >= lim)))
               || (is_lookup && (req.item.lookup_id == 64'd0));

  assign req.ready = !busy;
  assign req_fire  = req.valid && !busy;

  assign tail = chain[SLOTS-1];
  assign adv  = !(tail.valid && rsp.valid && !rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else if (req_fire) begin
      entry.valid         <= 1'b1;
      entry.rej           <= rej;
      entry.hit           <= 1'b0;
      entry.cmd           <= req.item.cmd;
      entry.id            <= is_record ? next_ident : req.item.lookup_id;
      entry.ev.kind       <= req.item.event_type;
      entry.ev.user       <= req.item.user_ident;
      entry.ev.session    <= req.item.session_ident;
      entry.ev.code       <= req.item.event_code;
      entry.ev.stamp      <= req.item.stamp;
    end else if (adv) begin
      entry.valid <= 1'b0;
    end
  end

  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    if (k == 0) begin : g_head
      est_cell #(.CELL_INDEX(k)) u_cell (
        .clk        (clk),
        .rst        (rst),
        .adv        (adv),
        .slot_limit (slot_limit),
        .pkt_in     (entry),
        .pkt_out    (chain[k])
      );
    end else begin : g_body
      est_cell #(.CELL_INDEX(k)) u_cell (
        .clk        (clk),
        .rst        (rst),
        .adv        (adv),
        .slot_limit (slot_limit),
        .pkt_in     (chain[k-1]),
        .pkt_out    (chain[k])
      );
    end
  end

  assign ok = !tail.rej && tail.hit;

  always_comb begin
    rsp_next = '0;
    rsp_next.failed = !ok;
    if (ok) begin
      rsp_next.out_id = tail.id;
      if (tail.cmd != CMD_CLEAR) begin
        rsp_next.out_type    = tail.ev.kind;
        rsp_next.out_user    = tail.ev.user;
        rsp_next.out_session = tail.ev.session;
        rsp_next.out_code    = tail.ev.code;
        rsp_next.out_stamp   = tail.ev.stamp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid    <= 1'b0;
      busy         <= 1'b0;
      next_ident   <= 64'd1;
      active_count <= 7'd0;
    end else begin
      if (req_fire) begin
        busy <= 1'b1;
      end
      if (adv && tail.valid) begin
        rsp.valid <= 1'b1;
        rsp.item  <= rsp_next;
        busy      <= 1'b0;
        if (ok && (tail.cmd == CMD_RECORD)) begin
          next_ident   <= (next_ident == '1) ? 64'd1 : next_ident + 64'd1;
          active_count <= active_count + 7'd1;
        end else if (ok && (tail.cmd == CMD_CLEAR) && (active_count != 7'd0)) begin
          active_count <= active_count - 7'd1;
        end
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/est_checker.sv =====
// port-level checks for the event slot table, bound to the top level
module est_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input est_pkg::rsp_t rsp_item
);
  import est_pkg::*;

  // one command in flight
  a_single_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("command accepted while another is in flight");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
    else $error("stalled result changed");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_item.failed |-> rsp_item.out_id == 64'd0
      && rsp_item.out_stamp == 64'd0 && rsp_item.out_user == 32'd0)
    else $error("failed result carries data");

  a_ok_id: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_item.failed |-> rsp_item.out_id != 64'd0)
    else $error("successful result with zero identifier");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid right after reset");

endmodule

bind event_slot_table_top est_checker u_est_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_item  (rsp.item)
);

// ===== sim/tb_top.sv =====
// self-checking testbench for the event slot table: directed and random commands
module tb_top;
  import est_pkg::*;

  localparam int SLOTS = SLOTS_DEFAULT;
  localparam int STALL_LIMIT = 1000;
  localparam int NUM_PHASES = 10;
  localparam int PRINT_CAP = 200;
  localparam logic [1:0] CMD_BAD = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);
  localparam logic [63:0] ALL_ONES = '1;

  logic clk;
  logic rst;

  est_req_if req_ch ();
  est_rsp_if rsp_ch ();
  est_cfg_if cfg_ch ();

  event_slot_table_top #(.SLOTS(SLOTS)) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  // mirror of the table contents and registers
  logic [63:0] tbl_ident [SLOTS];
  event_t tbl_ev [SLOTS];
  logic [63:0] id_next;
  int live_count;
  logic [CFG_DATA_W-1:0] lim_reg;
  logic run_flag;

  req_t cmd_backlog [$];
  rsp_t rsp_due [$];
  int cmds_issued = 0;
  int rsps_seen = 0;
  int errors = 0;
  int quiet_cycles = 0;
  int send_idle = 35;
  int recv_idle = 73;
  logic req_taken = 1'b0;

  int phase_limit [NUM_PHASES] = '{64, 3, 127, 64, 0, 17, 64, 1, 40, 64};
  int phase_on [NUM_PHASES] = '{1, 1, 1, 1, 1, 1, 1, 1, 0, 1};
  int phase_rec [NUM_PHASES] = '{70, 50, 85, 20, 50, 50, 55, 50, 50, 45};
  int phase_count [NUM_PHASES] = '{200, 150, 200, 200, 40, 200, 250, 150, 60, 300};

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_error(input string msg);
    errors++;
    if (errors <= PRINT_CAP) $display("mismatch at result %0d: %s", rsps_seen, msg);
  endtask

  task automatic cmp_field(input string name, input logic [63:0] got, input logic [63:0] want);
    if (got !== want) report_error($sformatf("%s got %h want %h", name, got, want));
  endtask

  function automatic rsp_t apply_to_table(input req_t c);
    rsp_t r;
    int span;
    int hit;
    r = '0;
    r.failed = 1'b1;
    span = (lim_reg > SLOTS) ? SLOTS : int'(lim_reg);
    hit = -1;
    if (!run_flag) return r;
    case (c.cmd)
      CMD_RECORD: begin
        if (c.event_type < EVENT_TYPES && live_count < span)
          for (int i = 0; i < span && hit < 0; i++)
            if (tbl_ident[i] == '0) hit = i;
        if (hit >= 0) begin
          tbl_ident[hit] = id_next;
          tbl_ev[hit].kind = c.event_type;
          tbl_ev[hit].user = c.user_ident;
          tbl_ev[hit].session = c.session_ident;
          tbl_ev[hit].code = c.event_code;
          tbl_ev[hit].stamp = c.stamp;
          r.failed = 1'b0;
          r.out_id = id_next;
          r.out_type = c.event_type;
          r.out_user = c.user_ident;
          r.out_session = c.session_ident;
          r.out_code = c.event_code;
          r.out_stamp = c.stamp;
          id_next = id_next + 64'd1;
          if (id_next == '0) id_next = 64'd1;
          live_count++;
        end
      end
      CMD_READ, CMD_CLEAR: begin
        if (c.lookup_id != '0)
          for (int i = 0; i < span && hit < 0; i++)
            if (tbl_ident[i] == c.lookup_id) hit = i;
        if (hit >= 0) begin
          r.failed = 1'b0;
          if (c.cmd == CMD_READ) begin
            r.out_id = tbl_ident[hit];
            r.out_type = tbl_ev[hit].kind;
            r.out_user = tbl_ev[hit].user;
            r.out_session = tbl_ev[hit].session;
            r.out_code = tbl_ev[hit].code;
            r.out_stamp = tbl_ev[hit].stamp;
          end else begin
            r.out_id = c.lookup_id;
            tbl_ident[hit] = '0;
            tbl_ev[hit] = '0;
            if (live_count > 0) live_count--;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic req_t make_cmd(input int rec_pct);
    req_t c;
    logic [63:0] live [$];
    int roll;
    c.cmd = CMD_RECORD;
    c.event_type = 2'($urandom_range(3));
    c.user_ident = $urandom;
    c.session_ident = $urandom;
    c.event_code = $urandom;
    c.stamp = {$urandom, $urandom};
    c.lookup_id = {$urandom, $urandom};
    for (int i = 0; i < SLOTS; i++)
      if (tbl_ident[i] != '0) live.push_back(tbl_ident[i]);
    roll = $urandom_range(99);
    if (roll < 6) begin
      c.cmd = ($urandom_range(1) == 0) ? CMD_READ : CMD_CLEAR;
      case ($urandom_range(3))
        0: c.cmd = CMD_BAD;
        1: c.lookup_id = '0;
        2: ;
        default: c.lookup_id = id_next;
      endcase
    end else if (roll >= 6 + rec_pct && live.size() != 0) begin
      c.cmd = ($urandom_range(1) == 0) ? CMD_READ : CMD_CLEAR;
      c.lookup_id = live[$urandom_range(live.size() - 1)];
    end
    return c;
  endfunction

  task automatic push_cmd(input logic [1:0] op, input logic [1:0] kind,
                          input logic [31:0] user, input logic [31:0] session,
                          input logic [31:0] code, input logic [63:0] stamp,
                          input logic [63:0] id);
    req_t c;
    c.cmd = op;
    c.event_type = kind;
    c.user_ident = user;
    c.session_ident = session;
    c.event_code = code;
    c.stamp = stamp;
    c.lookup_id = id;
    cmd_backlog.push_back(c);
    cmds_issued++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_t w;
    w.index = idx;
    w.data = val;
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.item <= w;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (rsps_seen != cmds_issued) @(negedge clk);
  endtask

  // command driver
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_taken) begin
      if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle) begin
        req_ch.item <= cmd_backlog.pop_front();
        req_ch.valid <= 1'b1;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= recv_idle);
  end

  // monitor, predictor update and watchdog
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        tbl_ident[i] = '0;
        tbl_ev[i] = '0;
      end
      id_next = 64'd1;
      live_count = 0;
      lim_reg = CFG_DATA_W'(64);
      run_flag = 1'b0;
      quiet_cycles = 0;
      req_taken <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        rsps_seen++;
        if (rsp_due.size() == 0) begin
          report_error("result with no command outstanding");
        end else begin
          want = rsp_due.pop_front();
          cmp_field("failed", 64'(rsp_ch.item.failed), 64'(want.failed));
          cmp_field("out_id", rsp_ch.item.out_id, want.out_id);
          cmp_field("out_type", 64'(rsp_ch.item.out_type), 64'(want.out_type));
          cmp_field("out_user", 64'(rsp_ch.item.out_user), 64'(want.out_user));
          cmp_field("out_session", 64'(rsp_ch.item.out_session), 64'(want.out_session));
          cmp_field("out_code", 64'(rsp_ch.item.out_code), 64'(want.out_code));
          cmp_field("out_stamp", rsp_ch.item.out_stamp, want.out_stamp);
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.item.index == REG_SLOT_LIMIT) lim_reg = cfg_ch.item.data;
        else if (cfg_ch.item.index == REG_ENABLE) run_flag = cfg_ch.item.data[0];
      end
      if (req_ch.valid && req_ch.ready) rsp_due.push_back(apply_to_table(req_ch.item));
      req_taken <= req_ch.valid && req_ch.ready;
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    int made;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.item = '0;
    rsp_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.item = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // disabled after reset
    push_cmd(CMD_RECORD, 2'd1, $urandom, $urandom, $urandom, {$urandom, $urandom}, '0);
    push_cmd(CMD_READ, 2'd0, '0, '0, '0, '0, 64'd1);
    push_cmd(CMD_CLEAR, 2'd0, '0, '0, '0, '0, 64'd1);
    wait_idle();
    write_reg(REG_SLOT_LIMIT, CFG_DATA_W'(64));
    write_reg(REG_ENABLE, CFG_DATA_W'(1));
    write_reg(REG_SPARE, '1);

    // field extremes, lookups, zero and unknown ids, unknown command
    push_cmd(CMD_RECORD, 2'd0, '0, '0, '0, '0, '0);
    push_cmd(CMD_RECORD, 2'd3, '1, '1, '1, ALL_ONES, ALL_ONES);
    push_cmd(CMD_RECORD, 2'd2, $urandom, $urandom, $urandom, {$urandom, $urandom}, '0);
    push_cmd(CMD_READ, 2'd0, '0, '0, '0, '0, 64'd1);
    push_cmd(CMD_READ, 2'd0, '0, '0, '0, '0, 64'd2);
    push_cmd(CMD_READ, 2'd0, '0, '0, '0, '0, '0);
    push_cmd(CMD_READ, 2'd0, '0, '0, '0, '0, ALL_ONES);
    push_cmd(CMD_CLEAR, 2'd0, '0, '0, '0, '0, '0);
    push_cmd(CMD_CLEAR, 2'd0, '0, '0, '0, '0, 64'd1);
    push_cmd(CMD_READ, 2'd0, '0, '0, '0, '0, 64'd1);
    push_cmd(CMD_CLEAR, 2'd0, '0, '0, '0, '0, 64'd1);
    push_cmd(CMD_BAD, 2'd1, '1, '1, '1, ALL_ONES, 64'd2);
    push_cmd(CMD_RECORD, 2'd1, $urandom, $urandom, $urandom, {$urandom, $urandom}, '0);
    wait_idle();

    // limit lowered below the active count: hidden slots still count
    write_reg(REG_SLOT_LIMIT, CFG_DATA_W'(2));
    push_cmd(CMD_RECORD, 2'd1, $urandom, $urandom, $urandom, {$urandom, $urandom}, '0);
    push_cmd(CMD_READ, 2'd0, '0, '0, '0, '0, 64'd3);
    push_cmd(CMD_CLEAR, 2'd0, '0, '0, '0, '0, 64'd2);
    push_cmd(CMD_RECORD, 2'd2, $urandom, $urandom, $urandom, {$urandom, $urandom}, '0);
    wait_idle();
    write_reg(REG_SLOT_LIMIT, '0);
    push_cmd(CMD_RECORD, 2'd3, $urandom, $urandom, $urandom, {$urandom, $urandom}, '0);
    push_cmd(CMD_READ, 2'd0, '0, '0, '0, '0, 64'd4);
    wait_idle();
    write_reg(REG_SLOT_LIMIT, '1);
    push_cmd(CMD_READ, 2'd0, '0, '0, '0, '0, 64'd3);
    push_cmd(CMD_RECORD, 2'd0, $urandom, $urandom, $urandom, {$urandom, $urandom}, '0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      if (p < 3) begin
        send_idle = 35;
        recv_idle = 73;
      end else if (p < 6) begin
        send_idle = 73;
        recv_idle = 35;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      write_reg(REG_SLOT_LIMIT, CFG_DATA_W'(phase_limit[p]));
      write_reg(REG_ENABLE, CFG_DATA_W'(phase_on[p]));
      made = 0;
      while (made < phase_count[p]) begin
        @(negedge clk);
        if (cmd_backlog.size() < 2) begin
          cmd_backlog.push_back(make_cmd(phase_rec[p]));
          cmds_issued++;
          made++;
        end
      end
    end

    wait_idle();
    repeat (SLOTS + 8) @(negedge clk);
    if (rsp_due.size() != 0) report_error("commands left without a result");
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
